>>> sv/cdd_pkg.sv
// Package for the complex down-converter/decimator: constants, coefficient
// tables, shared types and arithmetic helpers. No dependencies.
package cdd_pkg;

    localparam int SampleBits   = 24;
    localparam int NumSections  = 4;
    localparam int BlockLength  = 4096;
    localparam int RenormPeriod = 8192;
    localparam int QueueDepth   = 2;

    localparam logic [1:0] RegPhaseCos = 2'd0;
    localparam logic [1:0] RegPhaseSin = 2'd1;
    localparam logic [1:0] RegDecim    = 2'd2;
    localparam logic [1:0] RegMaxOut   = 2'd3;

    localparam logic signed [31:0] Q30One = 32'sh4000_0000;
    localparam logic signed [47:0] W48Max = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] W48Min = {1'b1, {47{1'b0}}};

    typedef logic signed [SampleBits-1:0] sample_t;
    typedef logic signed [47:0] word_t;

    // Work handed from the front end to the filter back end.
    typedef struct packed {
        logic        clear;
        logic signed [47:0] mix_re;
        logic signed [47:0] mix_im;
        logic        emit;
        logic [11:0] index;
        logic        last;
    } job_t;

    typedef enum logic [2:0] {
        FE_IDLE, FE_MIX, FE_ROT, FE_NORM_M, FE_NORM_S, FE_NORM_G, FE_NORM_P, FE_PUSH
    } fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE, BE_MUL, BE_MUL_HI, BE_SUM, BE_OUT
    } be_state_t;

    function automatic logic signed [27:0] coef_a1(input logic [1:0] s);
        case (s)
            2'd0:    coef_a1 = -28'sd32963874;
            2'd1:    coef_a1 = -28'sd32744092;
            2'd2:    coef_a1 = -28'sd32648462;
            default: coef_a1 = -28'sd32621619;
        endcase
    endfunction

    function automatic logic signed [27:0] coef_a2(input logic [1:0] s);
        case (s)
            2'd0:    coef_a2 = 28'sd16594344;
            2'd1:    coef_a2 = 28'sd16260478;
            2'd2:    coef_a2 = 28'sd16008820;
            default: coef_a2 = 28'sd15872924;
        endcase
    endfunction

    // Round a 66-bit value by 2^30 (ties up) and saturate to 32 bits.
    function automatic logic signed [31:0] rnd30_sat(input logic signed [65:0] p);
        logic signed [65:0] r;
        begin
            r = (p + 66'sd536870912) >>> 30;
            if (r > 66'sd2147483647)
                rnd30_sat = 32'sh7FFF_FFFF;
            else if (r < -66'sd2147483648)
                rnd30_sat = 32'sh8000_0000;
            else
                rnd30_sat = r[31:0];
        end
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [51:0] v);
        if (v > 52'(W48Max))
            sat48 = W48Max;
        else if (v < 52'(W48Min))
            sat48 = W48Min;
        else
            sat48 = v[47:0];
    endfunction

endpackage

>>> sv/cdd_if.sv
// Valid/ready stream interfaces for the down-converter channels.
// Depends on cdd_pkg.
interface cdd_in_if;
    logic                    valid;
    logic                    ready;
    logic signed [cdd_pkg::SampleBits-1:0] sample;
    logic                    start_block;
    modport source (output valid, sample, start_block, input ready);
    modport sink (input valid, sample, start_block, output ready);
endinterface

interface cdd_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] out_i;
    logic signed [47:0] out_q;
    logic [11:0]        out_index;
    logic               last;
    modport source (output valid, out_i, out_q, out_index, last, input ready);
    modport sink (input valid, out_i, out_q, out_index, last, output ready);
endinterface

interface cdd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/cdd_front.sv
// Front end: oscillator mixing, rotation, renormalization and output
// bookkeeping. Pushes one job per live sample. Depends on cdd_pkg.
module cdd_front (
    input  logic        clk,
    input  logic        rst_n,
    cdd_in_if.sink      in_ch,
    input  logic signed [31:0] phase_cos,
    input  logic signed [31:0] phase_sin,
    input  logic [6:0]  decimation,
    input  logic [12:0] max_outputs,
    output cdd_pkg::job_t job,
    output logic        job_valid,
    input  logic        job_ready
);
    import cdd_pkg::*;

    fe_state_t state_reg, state_next;
    logic signed [31:0] osc_re_reg, osc_re_next, osc_im_reg, osc_im_next;
    logic [12:0] renorm_reg, renorm_next;
    logic [5:0]  decim_reg, decim_next;
    logic [12:0] outcnt_reg, outcnt_next;
    logic        renorm_apply_reg, renorm_apply_next;
    sample_t     x_reg, x_next;
    logic        clear_reg, clear_next;
    logic signed [63:0] p0_reg, p0_next, p1_reg, p1_next;
    logic signed [63:0] p2_reg, p2_next, p3_reg, p3_next;
    logic signed [31:0] g_reg, g_next;
    job_t        job_reg, job_next;

    logic [12:0] limit;
    logic [6:0]  dec;
    logic signed [34:0] m_sum;
    logic signed [35:0] g_raw;
    logic signed [31:0] nr, ni;
    logic        emit;

    always_comb
    begin
        limit = (max_outputs < 13'(BlockLength)) ? max_outputs : 13'(BlockLength);
        dec = (decimation == 7'd0) ? 7'd1 : ((decimation > 7'd64) ? 7'd64 : decimation);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= FE_IDLE;
            osc_re_reg       <= Q30One;
            osc_im_reg       <= '0;
            renorm_reg       <= '0;
            decim_reg        <= '0;
            outcnt_reg       <= '0;
            renorm_apply_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            osc_re_reg       <= osc_re_next;
            osc_im_reg       <= osc_im_next;
            renorm_reg       <= renorm_next;
            decim_reg        <= decim_next;
            outcnt_reg       <= outcnt_next;
            renorm_apply_reg <= renorm_apply_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        clear_reg <= clear_next;
        p0_reg    <= p0_next;
        p1_reg    <= p1_next;
        p2_reg    <= p2_next;
        p3_reg    <= p3_next;
        g_reg     <= g_next;
        job_reg   <= job_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        osc_re_next = osc_re_reg;
        osc_im_next = osc_im_reg;
        renorm_next = renorm_reg;
        decim_next  = decim_reg;
        outcnt_next = outcnt_reg;
        renorm_apply_next = renorm_apply_reg;
        x_next      = x_reg;
        clear_next  = clear_reg;
        p0_next     = p0_reg;
        p1_next     = p1_reg;
        p2_next     = p2_reg;
        p3_next     = p3_reg;
        g_next      = g_reg;
        job_next    = job_reg;
        in_ch.ready = 1'b0;
        job_valid   = 1'b0;
        nr = rnd30_sat(66'(p0_reg) - 66'(p1_reg));
        ni = rnd30_sat(66'(p2_reg) + 66'(p3_reg));
        m_sum = 35'((66'(p0_reg) + 66'sd536870912) >>> 30)
              + 35'((66'(p1_reg) + 66'sd536870912) >>> 30);
        g_raw = (36'sd3221225472 - 36'(m_sum)) >>> 1;
        emit = 1'b0;
        case (state_reg)
            FE_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    x_next = in_ch.sample;
                    clear_next = in_ch.start_block;
                    if (in_ch.start_block)
                    begin
                        osc_re_next = Q30One;
                        osc_im_next = '0;
                        renorm_next = '0;
                        decim_next = '0;
                        outcnt_next = '0;
                        if (limit != 13'd0)
                            state_next = FE_MIX;
                        else
                        begin
                            // Filter state must still be cleared.
                            job_next.clear = 1'b1;
                            job_next.mix_re = '0;
                            job_next.mix_im = '0;
                            job_next.emit = 1'b0;
                            job_next.index = '0;
                            job_next.last = 1'b0;
                            state_next = FE_PUSH;
                        end
                    end
                    else if (outcnt_reg < limit)
                        state_next = FE_MIX;
                end
            end
            FE_MIX:
            begin
                p0_next = 64'(osc_re_reg * x_reg);
                p1_next = 64'(osc_im_reg * x_reg);
                state_next = FE_ROT;
            end
            FE_ROT:
            begin
                job_next.clear = clear_reg;
                job_next.mix_re = 48'((p0_reg + (64'sd1 <<< (SampleBits + 4)))
                                      >>> (SampleBits + 5));
                job_next.mix_im = 48'((p1_reg + (64'sd1 <<< (SampleBits + 4)))
                                      >>> (SampleBits + 5));
                p0_next = 64'(osc_re_reg * phase_cos);
                p1_next = 64'(osc_im_reg * phase_sin);
                p2_next = 64'(osc_re_reg * phase_sin);
                p3_next = 64'(osc_im_reg * phase_cos);
                if (7'({1'b0, decim_reg} + 7'd1) >= dec)
                begin
                    emit = 1'b1;
                    decim_next = '0;
                    outcnt_next = outcnt_reg + 13'd1;
                end
                else
                    decim_next = decim_reg + 6'd1;
                job_next.emit = emit;
                job_next.index = outcnt_reg[11:0];
                job_next.last = (outcnt_reg + 13'd1 == limit);
                state_next = FE_NORM_M;
            end
            FE_NORM_M:
            begin
                osc_re_next = nr;
                osc_im_next = ni;
                if (renorm_reg == 13'(RenormPeriod - 1))
                begin
                    renorm_next = '0;
                    state_next = FE_NORM_S;
                end
                else
                begin
                    renorm_next = renorm_reg + 13'd1;
                    state_next = FE_PUSH;
                end
            end
            FE_NORM_S:
            begin
                p0_next = 64'(osc_re_reg * osc_re_reg);
                p1_next = 64'(osc_im_reg * osc_im_reg);
                state_next = FE_NORM_G;
            end
            FE_NORM_G:
            begin
                // A zero magnitude leaves the oscillator as it is.
                renorm_apply_next = (m_sum != 35'sd0);
                if (g_raw > 36'sd2147483647)
                    g_next = 32'sh7FFF_FFFF;
                else if (g_raw < -36'sd2147483648)
                    g_next = 32'sh8000_0000;
                else
                    g_next = g_raw[31:0];
                state_next = FE_NORM_P;
            end
            FE_NORM_P:
            begin
                p2_next = 64'(osc_re_reg * g_reg);
                p3_next = 64'(osc_im_reg * g_reg);
                state_next = FE_PUSH;
            end
            FE_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = FE_IDLE;
                    if (renorm_apply_reg)
                    begin
                        osc_re_next = rnd30_sat(66'(p2_reg));
                        osc_im_next = rnd30_sat(66'(p3_reg));
                    end
                    renorm_apply_next = 1'b0;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

    assign job = job_reg;

endmodule

>>> sv/cdd_queue.sv
// Short job queue between front end and filter back end.
// Depends on cdd_pkg.
module cdd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  cdd_pkg::job_t wr_job,
    input  logic          wr_valid,
    output logic          wr_ready,
    output cdd_pkg::job_t rd_job,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import cdd_pkg::*;

    job_t mem_reg [QueueDepth];
    logic [$clog2(QueueDepth)-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [$clog2(QueueDepth):0] cnt_reg, cnt_next;
    logic push, pop;

    assign wr_ready = (cnt_reg != ($clog2(QueueDepth)+1)'(QueueDepth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_job   = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    always_comb
    begin
        wp_next = push ? wp_reg + 1'b1 : wp_reg;
        rp_next = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {{$clog2(QueueDepth){1'b0}}, push}
                 - {{$clog2(QueueDepth){1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_job;
    end

endmodule

>>> sv/cdd_back.sv
// Back end: biquad cascade, each section in multiply-low, multiply-high and sum
// steps on both rails, plus the output register. Depends on cdd_pkg.
module cdd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  cdd_pkg::job_t job,
    input  logic          job_valid,
    output logic          job_ready,
    cdd_out_if.source     out_ch
);
    import cdd_pkg::*;

    be_state_t state_reg, state_next;
    word_t z1r_reg [NumSections];
    word_t z1i_reg [NumSections];
    word_t z2r_reg [NumSections];
    word_t z2i_reg [NumSections];
    logic [$clog2(NumSections+1)-1:0] sec_reg, sec_next;
    word_t xr_reg, xr_next, xi_reg, xi_next;
    logic signed [51:0] m1r_reg, m1r_next, m2r_reg, m2r_next;
    logic signed [51:0] m1i_reg, m1i_next, m2i_reg, m2i_next;
    job_t  cur_reg, cur_next;
    logic  ov_reg, ov_next;
    word_t oi_reg, oi_next, oq_reg, oq_next;
    logic [11:0] oidx_reg, oidx_next;
    logic  olast_reg, olast_next;
    logic  upd, clr;
    word_t wr, wi, yr, yi;
    logic [$clog2(NumSections)-1:0] si;

    // Coefficient times the low 24 bits of a delay word, with the coefficient's 24
    // fractional bits rounded off; the high half is added in the following cycle.
    function automatic logic signed [51:0] mul_lo(input logic signed [27:0] a,
                                                 input word_t z);
        logic signed [52:0] p;
        begin
            p = 53'(a) * 53'(signed'({1'b0, z[23:0]}));
            mul_lo = 52'((p + 53'sd8388608) >>> 24);
        end
    endfunction

    function automatic logic signed [51:0] mul_hi(input logic signed [27:0] a,
                                                 input word_t z);
        mul_hi = 52'(a) * 52'(signed'(z[47:24]));
    endfunction

    assign si = sec_reg[$clog2(NumSections)-1:0];

    always_comb
    begin
        wr = sat48(52'(xr_reg) - m1r_reg - m2r_reg);
        wi = sat48(52'(xi_reg) - m1i_reg - m2i_reg);
        yr = sat48(52'(wr) + 52'(z1r_reg[si]) * 52'sd2 + 52'(z2r_reg[si]));
        yi = sat48(52'(wi) + 52'(z1i_reg[si]) * 52'sd2 + 52'(z2i_reg[si]));
    end

    always_comb
    begin
        state_next = state_reg;
        sec_next = sec_reg;
        xr_next = xr_reg;
        xi_next = xi_reg;
        m1r_next = m1r_reg;
        m2r_next = m2r_reg;
        m1i_next = m1i_reg;
        m2i_next = m2i_reg;
        cur_next = cur_reg;
        ov_next = ov_reg;
        oi_next = oi_reg;
        oq_next = oq_reg;
        oidx_next = oidx_reg;
        olast_next = olast_reg;
        job_ready = 1'b0;
        upd = 1'b0;
        clr = 1'b0;
        if (out_ch.valid && out_ch.ready)
            ov_next = 1'b0;
        case (state_reg)
            BE_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    cur_next = job;
                    clr = job.clear;
                    xr_next = job.mix_re;
                    xi_next = job.mix_im;
                    sec_next = '0;
                    state_next = BE_MUL;
                end
            end
            BE_MUL:
            begin
                m1r_next = mul_lo(coef_a1(2'(si)), z1r_reg[si]);
                m2r_next = mul_lo(coef_a2(2'(si)), z2r_reg[si]);
                m1i_next = mul_lo(coef_a1(2'(si)), z1i_reg[si]);
                m2i_next = mul_lo(coef_a2(2'(si)), z2i_reg[si]);
                state_next = BE_MUL_HI;
            end
            BE_MUL_HI:
            begin
                m1r_next = m1r_reg + mul_hi(coef_a1(2'(si)), z1r_reg[si]);
                m2r_next = m2r_reg + mul_hi(coef_a2(2'(si)), z2r_reg[si]);
                m1i_next = m1i_reg + mul_hi(coef_a1(2'(si)), z1i_reg[si]);
                m2i_next = m2i_reg + mul_hi(coef_a2(2'(si)), z2i_reg[si]);
                state_next = BE_SUM;
            end
            BE_SUM:
            begin
                upd = 1'b1;
                xr_next = yr;
                xi_next = yi;
                if (sec_reg == ($clog2(NumSections+1))'(NumSections - 1))
                    state_next = BE_OUT;
                else
                begin
                    sec_next = sec_reg + 1'b1;
                    state_next = BE_MUL;
                end
            end
            BE_OUT:
            begin
                if (!cur_reg.emit)
                    state_next = BE_IDLE;
                else if (!ov_next)
                begin
                    ov_next = 1'b1;
                    oi_next = xr_reg;
                    oq_next = xi_reg;
                    oidx_next = cur_reg.index;
                    olast_next = cur_reg.last;
                    state_next = BE_IDLE;
                end
            end
            default: state_next = BE_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_IDLE;
            ov_reg <= 1'b0;
            sec_reg <= '0;
            for (int k = 0; k < NumSections; k++)
            begin
                z1r_reg[k] <= '0;
                z1i_reg[k] <= '0;
                z2r_reg[k] <= '0;
                z2i_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
            sec_reg <= sec_next;
            if (clr)
            begin
                for (int k = 0; k < NumSections; k++)
                begin
                    z1r_reg[k] <= '0;
                    z1i_reg[k] <= '0;
                    z2r_reg[k] <= '0;
                    z2i_reg[k] <= '0;
                end
            end
            else if (upd)
            begin
                z1r_reg[si] <= wr;
                z1i_reg[si] <= wi;
                z2r_reg[si] <= z1r_reg[si];
                z2i_reg[si] <= z1i_reg[si];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        xr_reg <= xr_next;
        xi_reg <= xi_next;
        m1r_reg <= m1r_next;
        m2r_reg <= m2r_next;
        m1i_reg <= m1i_next;
        m2i_reg <= m2i_next;
        cur_reg <= cur_next;
        oi_reg <= oi_next;
        oq_reg <= oq_next;
        oidx_reg <= oidx_next;
        olast_reg <= olast_next;
    end

    assign out_ch.valid = ov_reg;
    assign out_ch.out_i = oi_reg;
    assign out_ch.out_q = oq_reg;
    assign out_ch.out_index = oidx_reg;
    assign out_ch.last = olast_reg;

endmodule

>>> sv/complex_downconverter_decimator.sv
// Complex down-converter with biquad lowpass cascade and decimation.
// Channels: in (sample, start_block), out (out_i, out_q, out_index, last),
// cfg (index, data) for phase_step_cos/sin, decimation and max_outputs.
// A beat on in is taken only while the front end is idle. The front end then
// mixes, rotates the oscillator and hands the job off to a two-entry job
// queue, and takes no new beat until the job is pushed; every 8192 mixed
// samples the oscillator renormalization adds the NORM_S, NORM_G and NORM_P
// states. The back end takes a job, runs the four sections through their
// multiply-low, multiply-high and sum steps and loads the output register,
// and takes no new job until that is done. Samples that cause no output
// still pass through the filter. When the receiver stalls, the output
// register holds its beat, the back end waits, the queue fills and
// in.ready stays low.
// Reset restores register defaults and clears oscillator, filters and counters.
// Configuration writes are always accepted and update the register at once; a sample in progress may see them.
module complex_downconverter_decimator (
    input  logic   clk,
    input  logic   rst_n,
    cdd_in_if.sink   in,
    cdd_out_if.source out,
    cdd_cfg_if.sink  cfg
);
    import cdd_pkg::*;

    logic signed [31:0] cos_reg, sin_reg;
    logic [6:0]  dec_reg;
    logic [12:0] max_reg;
    job_t fj, qj;
    logic fv, fr, qv, qr;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= Q30One;
            sin_reg <= '0;
            dec_reg <= 7'd16;
            max_reg <= 13'd4096;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                RegPhaseCos: cos_reg <= cfg.data;
                RegPhaseSin: sin_reg <= cfg.data;
                RegDecim:    dec_reg <= cfg.data[6:0];
                RegMaxOut:   max_reg <= cfg.data[12:0];
                default:     ;
            endcase
        end
    end

    cdd_front u_front (
        .clk, .rst_n, .in_ch(in),
        .phase_cos(cos_reg), .phase_sin(sin_reg),
        .decimation(dec_reg), .max_outputs(max_reg),
        .job(fj), .job_valid(fv), .job_ready(fr)
    );

    cdd_queue u_queue (
        .clk, .rst_n,
        .wr_job(fj), .wr_valid(fv), .wr_ready(fr),
        .rd_job(qj), .rd_valid(qv), .rd_ready(qr)
    );

    cdd_back u_back (
        .clk, .rst_n, .job(qj), .job_valid(qv), .job_ready(qr), .out_ch(out)
    );

endmodule

>>> tb/cdd_tb_if.sv
// Testbench-side note: the channel interfaces come from sv/cdd_if.sv.
// This file holds shared testbench types for the stimulus and the expected results; depends on cdd_pkg.
package cdd_tb_pkg;
    import cdd_pkg::*;

    typedef struct {
        logic signed [SampleBits-1:0] sample;
        logic                         start_block;
    } sample_beat_t;

    typedef struct {
        logic signed [47:0] out_i;
        logic signed [47:0] out_q;
        logic [11:0]        out_index;
        logic               last;
    } dec_result_t;
endpackage

>>> tb/testbench.sv
// Testbench for complex_downconverter_decimator: random and directed samples,
// a bit-exact predictor of the mixer, oscillator, biquads and decimator,
// and a scoreboard. Depends on cdd_pkg, cdd_tb_pkg and the channel interfaces.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import cdd_pkg::*;
    import cdd_tb_pkg::*;

    localparam longint CycleLimit = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cdd_in_if  in_ch ();
    cdd_out_if out_ch ();
    cdd_cfg_if cfg_ch ();

    complex_downconverter_decimator u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state.
    longint p_cos, p_sin, p_dec, p_max;
    longint osc_re, osc_im, renorm_cnt, decim_cnt, out_cnt;
    longint delay_line [16];
    longint a1_tab [4] = '{-32963874, -32744092, -32648462, -32621619};
    longint a2_tab [4] = '{16594344, 16260478, 16008820, 15872924};

    sample_beat_t pending_samples [$];
    dec_result_t  expected_results [$];
    int  mismatches = 0;
    bit  quiet = 1'b0;
    bit  cfg_busy = 1'b0;
    logic [1:0]  cfg_idx_q;
    logic [31:0] cfg_data_q;
    longint cycles = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Exact round of (p1 + sgn*p2) / 2^30 with ties up.
    function automatic longint round30(longint p1, longint p2, int sgn);
        longint l1, l2, hi, lo;
        l1 = p1 & ((64'sd1 << 30) - 1);
        l2 = p2 & ((64'sd1 << 30) - 1);
        if (sgn >= 0)
        begin
            hi = asr(p1, 30) + asr(p2, 30);
            lo = l1 + l2;
        end
        else
        begin
            hi = asr(p1, 30) - asr(p2, 30);
            lo = l1 - l2;
        end
        return hi + asr(lo + (64'sd1 << 29), 30);
    endfunction

    function automatic longint coef_mul(longint a, longint z);
        longint zl, zh;
        zl = z & 64'hFFFFFF;
        zh = asr(z, 24);
        return a * zh + asr(a * zl + (64'sd1 << 23), 24);
    endfunction

    task automatic clear_filter_state();
        osc_re = 64'sd1 << 30;
        osc_im = 0;
        renorm_cnt = 0;
        decim_cnt = 0;
        out_cnt = 0;
        foreach (delay_line[k]) delay_line[k] = 0;
    endtask

    function automatic longint biquad(int s, longint x, int part);
        longint z1, z2, w, y;
        longint wmax, wmin;
        wmax = (64'sd1 << 47) - 1;
        wmin = -(64'sd1 << 47);
        z1 = delay_line[4*s + part];
        z2 = delay_line[4*s + 2 + part];
        w = clip(x - coef_mul(a1_tab[s % 4], z1) - coef_mul(a2_tab[s % 4], z2), wmin, wmax);
        y = clip(w + 2*z1 + z2, wmin, wmax);
        delay_line[4*s + 2 + part] = z1;
        delay_line[4*s + part] = w;
        return y;
    endfunction

    task automatic predict_sample(sample_beat_t b);
        longint lim, dec, x, mr, mi, nr, ni, m, g;
        longint imax, imin;
        dec_result_t r;
        imax = 64'sd2147483647;
        imin = -64'sd2147483648;
        lim = p_max < BlockLength ? p_max : BlockLength;
        dec = p_dec == 0 ? 1 : (p_dec > 64 ? 64 : p_dec);
        if (b.start_block)
            clear_filter_state();
        if (out_cnt >= lim)
            return;
        x = longint'(b.sample);
        mr = asr(osc_re * x + (64'sd1 << 28), 29);
        mi = asr(osc_im * x + (64'sd1 << 28), 29);
        nr = round30(osc_re * p_cos, osc_im * p_sin, -1);
        ni = round30(osc_re * p_sin, osc_im * p_cos, 1);
        osc_re = clip(nr, imin, imax);
        osc_im = clip(ni, imin, imax);
        renorm_cnt++;
        if (renorm_cnt >= RenormPeriod)
        begin
            renorm_cnt = 0;
            m = round30(osc_re * osc_re, 0, 1) + round30(osc_im * osc_im, 0, 1);
            // A zero magnitude leaves the oscillator untouched.
            if (m != 0)
            begin
                g = clip(asr(3 * (64'sd1 << 30) - m, 1), imin, imax);
                osc_re = clip(round30(osc_re * g, 0, 1), imin, imax);
                osc_im = clip(round30(osc_im * g, 0, 1), imin, imax);
            end
        end
        for (int s = 0; s < NumSections; s++)
        begin
            mr = biquad(s, mr, 0);
            mi = biquad(s, mi, 1);
        end
        decim_cnt++;
        if (decim_cnt < dec)
            return;
        decim_cnt = 0;
        r.out_i = mr[47:0];
        r.out_q = mi[47:0];
        r.out_index = out_cnt[11:0];
        r.last = (out_cnt + 1 == lim);
        out_cnt++;
        expected_results.insert(expected_results.size(), r);
    endtask

    // Sample driver.
    int in_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.sample <= '0;
            in_ch.start_block <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                sample_beat_t b;
                b.sample = in_ch.sample;
                b.start_block = in_ch.start_block;
                predict_sample(b);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_ch.valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_beat_t b;
                    b = pending_samples.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.sample <= b.sample;
                    in_ch.start_block <= b.start_block;
                    if (!quiet && $urandom_range(0, 9) == 0)
                        in_gap <= $urandom_range(1, 15);
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // Result monitor with its own stall bursts.
    int out_stall = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat idx=%0d", out_ch.out_index);
                end
                else
                begin
                    dec_result_t e;
                    e = expected_results.pop_front();
                    if (e.out_i !== out_ch.out_i || e.out_q !== out_ch.out_q ||
                        e.out_index !== out_ch.out_index || e.last !== out_ch.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp i=%0d q=%0d idx=%0d last=%0b",
                                      " got i=%0d q=%0d idx=%0d last=%0b"},
                                e.out_i, e.out_q, e.out_index, e.last,
                                out_ch.out_i, out_ch.out_q, out_ch.out_index, out_ch.last);
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0)
                    out_stall <= $urandom_range(1, 15);
            end
        end
    end

    // Configuration channel: one beat at a time, predictor updated on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= '0;
            cfg_ch.data <= '0;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                RegPhaseCos: p_cos = longint'(signed'(cfg_ch.data));
                RegPhaseSin: p_sin = longint'(signed'(cfg_ch.data));
                RegDecim:    p_dec = cfg_ch.data & 32'h7F;
                RegMaxOut:   p_max = cfg_ch.data & 32'h1FFF;
                default:     ;
            endcase
            cfg_ch.valid <= 1'b0;
            cfg_busy = 1'b0;
        end
        else if (cfg_busy && !cfg_ch.valid)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= cfg_idx_q;
            cfg_ch.data <= cfg_data_q;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_idx_q = idx;
        cfg_data_q = val;
        cfg_busy = 1'b1;
        while (cfg_busy) @(posedge clk);
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(posedge clk);
        // Samples that cause no result may still be in flight.
        repeat (100) @(posedge clk);
    endtask

    task automatic queue_sample(logic signed [23:0] s, logic sb);
        sample_beat_t b;
        b.sample = s;
        b.start_block = sb;
        pending_samples.insert(pending_samples.size(), b);
    endtask

    task automatic run_phase(int n, int start_pct);
        for (int k = 0; k < n; k++)
        begin
            logic signed [23:0] s;
            case ($urandom_range(0, 5))
                0: s = 24'sh7FFFFF;
                1: s = 24'sh800000;
                default: s = $urandom;
            endcase
            queue_sample(s, $urandom_range(0, 99) < start_pct);
        end
        drain();
    endtask

    initial
    begin
        cfg_busy = 1'b0;
        p_cos = 64'sd1 << 30;
        p_sin = 0;
        p_dec = 16;
        p_max = 4096;
        clear_filter_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: decimation one, short blocks, full-scale samples.
        write_reg(RegDecim, 32'd1);
        write_reg(RegMaxOut, 32'd3);
        queue_sample(24'sh7FFFFF, 1'b1);
        queue_sample(24'sh800000, 1'b0);
        queue_sample(24'sh000000, 1'b0);
        // Block finished: these are ignored.
        queue_sample(24'sh7FFFFF, 1'b0);
        queue_sample(24'sh123456, 1'b0);
        queue_sample(24'sh7FFFFF, 1'b1);
        queue_sample(24'shFFFFFF, 1'b0);
        drain();
        // Zero output limit: every sample ignored.
        write_reg(RegMaxOut, 32'd0);
        queue_sample(24'sh400000, 1'b1);
        queue_sample(24'sh400000, 1'b0);
        drain();
        // Decimation zero and above 64, full rotation steps.
        write_reg(RegMaxOut, 32'h1FFF);
        write_reg(RegDecim, 32'd0);
        write_reg(RegPhaseCos, 32'hC000_0000);
        write_reg(RegPhaseSin, 32'h0000_0000);
        queue_sample(24'sh7FFFFF, 1'b1);
        queue_sample(24'sh800000, 1'b0);
        queue_sample(24'sh555555, 1'b0);
        drain();
        write_reg(RegDecim, 32'h7F);
        write_reg(RegPhaseCos, 32'd0);
        write_reg(RegPhaseSin, 32'h4000_0000);
        for (int k = 0; k < 8; k++) queue_sample(24'sh7FFFFF, 1'b0);
        drain();
        // Counter beyond decimation once the register is lowered mid-block.
        write_reg(RegDecim, 32'd2);
        queue_sample(24'sh800000, 1'b0);
        queue_sample(24'sh000001, 1'b0);
        drain();

        // Random phases over several settings; the last one runs without idling.
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(RegPhaseCos, ph == 0 ? 32'h4000_0000
                                           : $urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
            write_reg(RegPhaseSin, ph == 1 ? 32'hC000_0000
                                           : $urandom_range(0, 32'h8000_0000) - 32'h4000_0000);
            write_reg(RegDecim, ph == 2 ? 32'd64 : $urandom_range(1, 8));
            write_reg(RegMaxOut, ph == 3 ? 32'd4096 : $urandom_range(1, 40));
            if (ph == 5) quiet = 1'b1;
            run_phase(155, 3);
        end

        if (mismatches == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> complex_downconverter_decimator.f
sv/cdd_pkg.sv
sv/cdd_if.sv
sv/cdd_front.sv
sv/cdd_queue.sv
sv/cdd_back.sv
sv/complex_downconverter_decimator.sv
tb/cdd_tb_if.sv
tb/testbench.sv
